// File: rtl/sbr_pkg.sv
// Shared types and constants for the stream byte reassembler.
// No dependencies; sbr_admit, the top level and the bench import this package.
package sbr_pkg;

  // Default window size in bytes; the top level hands it down
  localparam int unsigned SBR_CAPACITY = 32;
  // Upper bound on bytes delivered for one request
  localparam int unsigned MAX_DRAIN    = 32;
  localparam int unsigned DRAIN_W      = $clog2(MAX_DRAIN + 1);

  // Field widths
  localparam int unsigned IDX_W  = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CNT_W  = 6;

  // Stream port widths
  localparam int unsigned S_TDATA_W = 48;
  localparam int unsigned S_TUSER_W = 3;
  localparam int unsigned M_TDATA_W = 48;
  localparam int unsigned M_TUSER_W = 1;

  // Request commands
  typedef enum logic [1:0] {
    CMD_BYTE    = 2'd0,
    CMD_EMPTY   = 2'd1,
    CMD_CONSUME = 2'd2,
    CMD_NOP     = 2'd3
  } sbr_cmd_e;

  // Result kinds
  typedef enum logic {
    KIND_BYTE   = 1'b0,
    KIND_STATUS = 1'b1
  } sbr_kind_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_CHECK,
    ST_EMIT,
    ST_STATUS
  } sbr_state_e;

  // One accepted request
  typedef struct packed {
    sbr_cmd_e            cmd;
    logic [IDX_W-1:0]    stream_index;
    logic [BYTE_W-1:0]   data_byte;
    logic                seg_eof;
    logic                seg_last;
    logic [CNT_W-1:0]    consume_count;
  } sbr_item_t;

  // Scalar state seen by the admission logic
  typedef struct packed {
    logic [IDX_W-1:0] head;
    logic [CNT_W-1:0] held;
    logic             end_known;
    logic [IDX_W-1:0] end_index;
    logic             closed;
  } sbr_ctx_t;

  // Admission decision for one request
  typedef struct packed {
    logic             store;
    logic             set_end;
    logic [IDX_W-1:0] end_val;
    logic [CNT_W-1:0] held_n;
  } sbr_admit_t;

endpackage

// File: rtl/sbr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module sbr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/sbr_admit.sv
// Window admission for one request: store decision, ring address, end record
// and reader space update. Depends on sbr_pkg.
module sbr_admit #(
  parameter int unsigned CAPACITY = sbr_pkg::SBR_CAPACITY,
  localparam int unsigned PW      = $clog2(CAPACITY)
) (
  input  sbr_pkg::sbr_item_t  item_i,
  input  sbr_pkg::sbr_ctx_t   ctx_i,
  input  logic [PW-1:0]       ptr_i,
  input  logic [CAPACITY-1:0] present_i,
  output logic [PW-1:0]       addr_o,
  output sbr_pkg::sbr_admit_t admit_o
);
  import sbr_pkg::*;

  localparam logic [PW:0]    CAP_P = (PW+1)'(CAPACITY);
  localparam logic [CNT_W:0] CAP_C = (CNT_W+1)'(CAPACITY);

  logic [CNT_W:0]   avail;
  logic [IDX_W:0]   idx_w;
  logic [IDX_W:0]   win_end;
  logic [IDX_W-1:0] off_full;
  logic [PW:0]      addr_sum;
  logic             win_lt;
  logic             win_le;
  logic             in_win;
  logic             live;
  logic             eof_byte;
  logic             eof_empty;

  // Window bounds, compared on the unwrapped index
  always_comb begin
    avail   = CAP_C - {1'b0, ctx_i.held};
    idx_w   = {1'b0, item_i.stream_index};
    win_end = {1'b0, ctx_i.head} + (IDX_W+1)'(avail);
    win_lt  = idx_w < win_end;
    win_le  = idx_w <= win_end;
    in_win  = (item_i.stream_index >= ctx_i.head) && win_lt &&
              (!ctx_i.end_known || (item_i.stream_index < ctx_i.end_index));
  end

  // Ring address: offset from the head, folded once into the store
  always_comb begin
    off_full = item_i.stream_index - ctx_i.head;
    addr_sum = {1'b0, ptr_i} + {1'b0, off_full[PW-1:0]};
    addr_o   = (addr_sum >= CAP_P) ? PW'(addr_sum - CAP_P) : addr_sum[PW-1:0];
  end

  // Store, end of stream and reader space
  always_comb begin
    live      = !ctx_i.closed;
    eof_byte  = live && (item_i.cmd == CMD_BYTE) && item_i.seg_eof &&
                item_i.seg_last && win_lt && !ctx_i.end_known;
    eof_empty = live && (item_i.cmd == CMD_EMPTY) && item_i.seg_eof &&
                win_le && !ctx_i.end_known;

    admit_o.store   = live && (item_i.cmd == CMD_BYTE) && in_win && !present_i[addr_o];
    admit_o.set_end = eof_byte || eof_empty;
    admit_o.end_val = eof_byte ? (item_i.stream_index + IDX_W'(1)) : item_i.stream_index;

    if (item_i.cmd == CMD_CONSUME) begin
      admit_o.held_n = (item_i.consume_count >= ctx_i.held) ? '0 :
                       (ctx_i.held - item_i.consume_count);
    end else begin
      admit_o.held_n = ctx_i.held;
    end
  end

endmodule

// File: rtl/stream_byte_reassembler_top.sv
// Top level of the stream byte reassembler: sequencer, ring pointer, state
// registers and output register. Depends on sbr_pkg, sbr_ram, sbr_admit.
//
//  Port group  Dir  Payload (lowest bit first)
//  s_axis      in   tdata: stream_index, data_byte, consume_count
//                   tuser: cmd, seg_eof; tlast: seg_last
//  m_axis      out  tdata: out_byte, stream_ended, pending_count, next_expected
//                   tuser: kind; tlast: last
//
// One request at a time. Each delivered byte passes through CHECK, where the
// byte RAM read at the head pointer is registered, and then EMIT, where it is
// presented, as the single read port serves one entry at a time.
// Reset clears the present flags in flip-flops at once; no clearing pass.
// The output register lets the next request be taken while the status waits;
// a stalled sink holds the sequencer in its emit states.
module stream_byte_reassembler_top #(
  parameter int unsigned CAPACITY = sbr_pkg::SBR_CAPACITY
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [31:0] stream_index, [39:32] data_byte, [45:40] consume_count, [47:46] zero
  input  logic [sbr_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // [1:0] cmd, [2] seg_eof
  input  logic [sbr_pkg::S_TUSER_W-1:0] s_axis_tuser,
  input  logic                         s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [7:0] out_byte, [8] stream_ended, [14:9] pending_count,
  // [46:15] next_expected, [47] zero
  output logic [sbr_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // [0] kind
  output logic [sbr_pkg::M_TUSER_W-1:0] m_axis_tuser,
  output logic                         m_axis_tlast
);
  import sbr_pkg::*;

  localparam int unsigned PW = $clog2(CAPACITY);
  localparam logic [PW-1:0]    PTR_LAST = PW'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] CAP_C    = CNT_W'(CAPACITY);

  sbr_state_e state_q, state_d;

  sbr_item_t           item_q;
  sbr_item_t           item_in;
  logic [PW-1:0]       ptr_q, ptr_d;
  logic [CAPACITY-1:0] present_q, present_d;
  logic [IDX_W-1:0]    head_q, head_d;
  logic [CNT_W-1:0]    pending_q, pending_d;
  logic [CNT_W-1:0]    held_q, held_d;
  logic                end_known_q, end_known_d;
  logic [IDX_W-1:0]    end_index_q, end_index_d;
  logic                closed_q, closed_d;
  logic [DRAIN_W-1:0]  drain_q, drain_d;

  logic                 m_valid_q, m_valid_d;
  logic [M_TDATA_W-1:0] m_data_q, m_data_d;
  logic [M_TUSER_W-1:0] m_user_q, m_user_d;
  logic                 m_last_q, m_last_d;

  sbr_ctx_t      ctx;
  sbr_admit_t    admit;
  logic [PW-1:0] admit_addr;
  logic [BYTE_W-1:0] rd_byte;

  logic s_fire;
  logic out_free;
  logic can_drain;
  logic close_now;
  logic ram_we;
  logic emit_byte;
  logic emit_status;

  // Request unpacking
  always_comb begin
    item_in.cmd           = sbr_cmd_e'(s_axis_tuser[1:0]);
    item_in.seg_eof       = s_axis_tuser[2];
    item_in.stream_index  = s_axis_tdata[31:0];
    item_in.data_byte     = s_axis_tdata[39:32];
    item_in.consume_count = s_axis_tdata[45:40];
    item_in.seg_last      = s_axis_tlast;
  end

  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;

  // Admission
  always_comb begin
    ctx.head      = head_q;
    ctx.held      = held_q;
    ctx.end_known = end_known_q;
    ctx.end_index = end_index_q;
    ctx.closed    = closed_q;
  end

  sbr_admit #(.CAPACITY(CAPACITY)) u_admit (
    .item_i    (item_q),
    .ctx_i     (ctx),
    .ptr_i     (ptr_q),
    .present_i (present_q),
    .addr_o    (admit_addr),
    .admit_o   (admit)
  );

  // Byte store: written on admission, read at the head pointer
  sbr_ram #(.WIDTH(BYTE_W), .DEPTH(CAPACITY)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (admit_addr),
    .wdata_i (item_q.data_byte),
    .raddr_i (ptr_q),
    .rdata_o (rd_byte)
  );

  // Head run and stream end tests
  assign can_drain = (drain_q < DRAIN_W'(MAX_DRAIN)) && !closed_q && present_q[ptr_q] &&
                     (held_q < CAP_C) && (!end_known_q || (head_q < end_index_q));
  assign close_now = !closed_q && end_known_q && (head_q >= end_index_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (s_fire) state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_CHECK;
      ST_CHECK:  state_d = can_drain ? ST_EMIT : ST_STATUS;
      ST_EMIT:   if (out_free) state_d = ST_CHECK;
      ST_STATUS: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    ram_we        = (state_q == ST_UPDATE) && admit.store;
    emit_byte     = (state_q == ST_EMIT) && out_free;
    emit_status   = (state_q == ST_STATUS) && out_free;
  end

  // State updates
  always_comb begin
    ptr_d       = ptr_q;
    present_d   = present_q;
    head_d      = head_q;
    pending_d   = pending_q;
    held_d      = held_q;
    end_known_d = end_known_q;
    end_index_d = end_index_q;
    closed_d    = closed_q;
    drain_d     = drain_q;

    if (state_q == ST_UPDATE) begin
      drain_d = '0;
      held_d  = admit.held_n;
      if (admit.store) begin
        present_d[admit_addr] = 1'b1;
        pending_d             = pending_q + CNT_W'(1);
      end
      if (admit.set_end) begin
        end_known_d = 1'b1;
        end_index_d = admit.end_val;
      end
    end

    if (emit_byte) begin
      present_d[ptr_q] = 1'b0;
      ptr_d            = (ptr_q == PTR_LAST) ? '0 : ptr_q + PW'(1);
      head_d           = head_q + IDX_W'(1);
      held_d           = held_q + CNT_W'(1);
      drain_d          = drain_q + DRAIN_W'(1);
      if (pending_q != '0) begin
        pending_d = pending_q - CNT_W'(1);
      end
    end

    // Stream end: discard whatever is still stored
    if (emit_status && close_now) begin
      closed_d  = 1'b1;
      present_d = '0;
      pending_d = '0;
    end
  end

  // Output register
  always_comb begin
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    m_last_d  = m_last_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    if (emit_byte) begin
      m_valid_d = 1'b1;
      m_data_d  = {1'b0, head_d, pending_d, 1'b0, rd_byte};
      m_user_d  = M_TUSER_W'(KIND_BYTE);
      m_last_d  = 1'b0;
    end else if (emit_status) begin
      m_valid_d = 1'b1;
      m_data_d  = {1'b0, head_d, pending_d, closed_d, {BYTE_W{1'b0}}};
      m_user_d  = M_TUSER_W'(KIND_STATUS);
      m_last_d  = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ptr_q       <= '0;
      present_q   <= '0;
      head_q      <= '0;
      pending_q   <= '0;
      held_q      <= '0;
      end_known_q <= 1'b0;
      end_index_q <= '0;
      closed_q    <= 1'b0;
      drain_q     <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      present_q   <= present_d;
      head_q      <= head_d;
      pending_q   <= pending_d;
      held_q      <= held_d;
      end_known_q <= end_known_d;
      end_index_q <= end_index_d;
      closed_q    <= closed_d;
      drain_q     <= drain_d;
      m_valid_q   <= m_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      item_q <= item_in;
    end
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
    m_last_q <= m_last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

  // Checks
  a_pending_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= CAP_C) else $error("pending count beyond capacity");

  a_write_empty_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !present_q[admit_addr]) else $error("store overwrites a held byte");

  a_closed_cleared : assert property (@(posedge clk_i) disable iff (!rst_ni)
    closed_q |-> (present_q == '0)) else $error("bytes held after stream end");

  a_no_byte_after_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && (m_user_q == M_TUSER_W'(KIND_BYTE))) |-> !closed_q)
    else $error("byte result after stream end");

endmodule

// File: bench/tb_stream_byte_reassembler_top.sv
// Self-checking bench for stream_byte_reassembler_top: directed opening rows, random
// segments and reader consumes, then directed closing rows, each checked against an in-bench predictor.
// Depends on sbr_pkg and the RTL under rtl/.
module tb_stream_byte_reassembler_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sbr_pkg::*;

  localparam int unsigned CAP          = SBR_CAPACITY;
  localparam int unsigned RANDOM_ITEMS = 234;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  // tail margin covers a request that delivers up to MAX_DRAIN bytes
  localparam int unsigned TAIL_CYCLES  = 2 * MAX_DRAIN + 16;
  localparam int          NOT_TYPED    = -1;

  // One result as seen on m_axis
  typedef struct packed {
    sbr_kind_e         kind;
    logic [BYTE_W-1:0] out_byte;
    logic              stream_ended;
    logic [CNT_W-1:0]  pending;
    logic [IDX_W-1:0]  next_idx;
    logic              last;
  } delivery_t;

  // One row of the directed table
  typedef struct {
    sbr_item_t        item;
    bit               rel;       // stream_index is an offset from the current head
    bit               alt_nop;   // becomes a NOP when the end comes from an eof byte
    int               t_pending; // typed status expectation, or NOT_TYPED
    logic [IDX_W-1:0] t_next;
  } plan_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata;
  logic [S_TUSER_W-1:0]  s_axis_tuser;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic [M_TUSER_W-1:0]  m_axis_tuser;
  logic                  m_axis_tlast;

  // Predictor state
  logic [BYTE_W-1:0] win_data [CAP];
  bit                win_valid [CAP];
  bit [IDX_W-1:0]    head_idx;
  int unsigned       stored_cnt;
  int unsigned       unread_cnt;
  bit                end_seen;
  bit [IDX_W-1:0]    end_at;
  bit                out_closed;

  delivery_t   predicted_deliveries[$];
  plan_row_t   stimulus_plan[$];
  int unsigned closing_from;
  bit          end_by_byte;
  bit          calm;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  stream_byte_reassembler_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void push_delivery(sbr_kind_e k, logic [BYTE_W-1:0] b, logic ended,
                                        logic lst);
    delivery_t d;
    d.kind         = k;
    d.out_byte     = b;
    d.stream_ended = ended;
    d.pending      = stored_cnt[CNT_W-1:0];
    d.next_idx     = head_idx;
    d.last         = lst;
    predicted_deliveries.insert(predicted_deliveries.size(), d);
  endfunction

  // Apply one accepted request and queue the results it causes
  function automatic void reassemble_item(sbr_item_t it);
    longint unsigned idx;
    longint unsigned win_end;
    int unsigned     off;
    int unsigned     drained;
    logic [BYTE_W-1:0] b;
    idx     = 64'(it.stream_index);
    win_end = 64'(head_idx);
    win_end += CAP - unread_cnt;
    drained = 0;

    if (it.cmd == CMD_BYTE && !out_closed) begin
      if (idx >= head_idx && idx < win_end && (!end_seen || idx < end_at)) begin
        off = 32'(idx - head_idx);
        if (!win_valid[off]) begin
          win_data[off]  = it.data_byte;
          win_valid[off] = 1'b1;
          stored_cnt++;
        end
      end
      // eof only counts on the last byte of a segment that fits the window
      if (it.seg_eof && it.seg_last && idx < win_end && !end_seen) begin
        end_seen = 1'b1;
        end_at   = it.stream_index + 1;
      end
    end else if (it.cmd == CMD_EMPTY && !out_closed) begin
      if (it.seg_eof && idx <= win_end && !end_seen) begin
        end_seen = 1'b1;
        end_at   = it.stream_index;
      end
    end else if (it.cmd == CMD_CONSUME) begin
      unread_cnt = (it.consume_count >= unread_cnt) ? 0 : unread_cnt - it.consume_count;
    end

    // deliver the contiguous run at the head
    while (drained < MAX_DRAIN && !out_closed && win_valid[0] && unread_cnt < CAP &&
           (!end_seen || head_idx < end_at)) begin
      b = win_data[0];
      for (int k = 0; k < CAP - 1; k++) begin
        win_data[k]  = win_data[k+1];
        win_valid[k] = win_valid[k+1];
      end
      win_valid[CAP-1] = 1'b0;
      head_idx++;
      if (stored_cnt > 0) stored_cnt--;
      unread_cnt++;
      push_delivery(KIND_BYTE, b, 1'b0, 1'b0);
      drained++;
    end

    // stream end reached: drop everything still stored
    if (!out_closed && end_seen && head_idx >= end_at) begin
      out_closed = 1'b1;
      for (int k = 0; k < CAP; k++) win_valid[k] = 1'b0;
      stored_cnt = 0;
    end

    push_delivery(KIND_STATUS, '0, out_closed, 1'b1);
  endfunction

  // Present one request, wait for its handshake, then predict
  task automatic send_request(input sbr_item_t it);
    while (!calm && $urandom_range(0, 99) < 25) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, it.consume_count, it.data_byte, it.stream_index};
    s_axis_tuser  <= {it.seg_eof, it.cmd};
    s_axis_tlast  <= it.seg_last;
    do @(posedge clk_i); while (!s_axis_tready);
    reassemble_item(it);
  endtask

  // Request with random don't-care fields and no eof
  function automatic sbr_item_t filler_item(sbr_cmd_e c);
    sbr_item_t it;
    it.cmd           = c;
    it.stream_index  = $urandom;
    it.data_byte     = BYTE_W'($urandom_range(0, 255));
    it.seg_eof       = 1'b0;
    it.seg_last      = 1'($urandom_range(0, 1));
    it.consume_count = CNT_W'($urandom_range(0, 63));
    return it;
  endfunction

  function automatic void add_row(sbr_cmd_e c, bit rel, bit alt, logic [IDX_W-1:0] idx,
                                  logic [BYTE_W-1:0] d, bit eof, bit lst,
                                  logic [CNT_W-1:0] cons, int pend, logic [IDX_W-1:0] nxt);
    plan_row_t r;
    r.item.cmd           = c;
    r.item.stream_index  = idx;
    r.item.data_byte     = d;
    r.item.seg_eof       = eof;
    r.item.seg_last      = lst;
    r.item.consume_count = cons;
    r.rel                = rel;
    r.alt_nop            = alt;
    r.t_pending          = pend;
    r.t_next             = nxt;
    stimulus_plan.insert(stimulus_plan.size(), r);
  endfunction

  // Random segments, reader consumes and noise; the stream never ends here
  task automatic random_phase();
    int unsigned      sent;
    int unsigned      pick;
    int unsigned      off;
    int unsigned      len;
    int unsigned      lo;
    int unsigned      j;
    int unsigned      k;
    bit               head_last;
    logic [IDX_W-1:0] base;
    logic [IDX_W-1:0] win_end;
    logic [IDX_W-1:0] tmp;
    logic [IDX_W-1:0] order [CAP];
    sbr_item_t        it;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      calm    = (sent >= 110 && sent < 170);
      pick    = $urandom_range(0, 99);
      win_end = head_idx + (CAP - unread_cnt);
      if (pick < 65) begin
        if (pick < 4) begin
          // full window: free the reader, fill behind the head, head byte last
          it = filler_item(CMD_CONSUME);
          it.consume_count = '1;
          send_request(it);
          send_request(it);
          off       = 0;
          len       = CAP;
          head_last = 1'b1;
          sent += 2;
        end else begin
          off       = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          len       = $urandom_range(1, 8);
          head_last = 1'b0;
        end
        base = head_idx + off;
        for (k = 0; k < len; k++) order[k] = base + k;
        lo = head_last;
        for (k = len - 1; k > lo; k--) begin
          j        = $urandom_range(lo, k);
          tmp      = order[k];
          order[k] = order[j];
          order[j] = tmp;
        end
        for (k = len; k > 0; k--) begin
          it = filler_item(CMD_BYTE);
          it.stream_index = order[k-1];
          it.seg_last     = (order[k-1] == base + len - 1);
          send_request(it);
        end
        sent += len;
      end else if (pick < 85) begin
        it = filler_item(CMD_CONSUME);
        it.consume_count = CNT_W'($urandom_range(0, 1) ? $urandom_range(0, 63) :
                                                         $urandom_range(0, 6));
        send_request(it);
        sent++;
      end else begin
        it = filler_item(CMD_BYTE);
        case ($urandom_range(0, 5))
          0: it.stream_index = head_idx - $urandom_range(1, 64);
          1: begin
            // eof byte beyond the window: must not end the stream
            it.stream_index = win_end + $urandom_range(0, 3000);
            it.seg_eof      = 1'b1;
            it.seg_last     = 1'b1;
          end
          2: begin
            it.seg_eof  = 1'b1;
            it.seg_last = 1'b0;
          end
          3: it.cmd = CMD_EMPTY;
          4: begin
            it.cmd          = CMD_EMPTY;
            it.seg_eof      = 1'b1;
            it.stream_index = win_end + $urandom_range(1, 3000);
          end
          default: begin
            it.cmd     = CMD_NOP;
            it.seg_eof = 1'($urandom_range(0, 1));
          end
        endcase
        send_request(it);
      end
    end
    calm = 1'b0;
  endtask

  function automatic void check_field(string name, logic [IDX_W-1:0] want,
                                      logic [IDX_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Result checker
  always @(posedge clk_i) begin : result_check
    delivery_t got;
    delivery_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind         = sbr_kind_e'(m_axis_tuser[0]);
      got.out_byte     = m_axis_tdata[7:0];
      got.stream_ended = m_axis_tdata[8];
      got.pending      = m_axis_tdata[14:9];
      got.next_idx     = m_axis_tdata[46:15];
      got.last         = m_axis_tlast;
      if (predicted_deliveries.size() == 0) begin
        $error("result with nothing expected: kind %0d byte %0h", got.kind, got.out_byte);
        mismatch_count++;
      end else begin
        want = predicted_deliveries[0];
        predicted_deliveries.delete(0);
        check_field("kind", want.kind, got.kind);
        check_field("out_byte", want.out_byte, got.out_byte);
        check_field("stream_ended", want.stream_ended, got.stream_ended);
        check_field("pending_count", want.pending, got.pending);
        check_field("next_expected", want.next_idx, got.next_idx);
        check_field("last", want.last, got.last);
      end
    end
  end

  // Sink back-pressure
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 25);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    plan_row_t        r;
    delivery_t        st;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    s_axis_tlast  <= 1'b0;
    rst_ni        <= 1'b0;
    calm           = 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    end_by_byte    = 1'($urandom_range(0, 1));

    // Opening rows, from reset (head 0, empty reader)
    //       cmd          rel alt index          data  eof lst cons  pend       next
    add_row(CMD_NOP,      0, 0, 32'd0,         8'h00, 0, 0, 6'd0,  0,         32'd0);
    add_row(CMD_BYTE,     0, 0, 32'd1,         8'hA5, 0, 0, 6'd0,  1,         32'd0);
    // same index again: already stored, ignored
    add_row(CMD_BYTE,     0, 0, 32'd1,         8'h5A, 0, 1, 6'd0,  1,         32'd0);
    add_row(CMD_BYTE,     0, 0, 32'd0,         8'h00, 0, 0, 6'd0,  NOT_TYPED, 32'd0);
    // before the head
    add_row(CMD_BYTE,     0, 0, 32'd0,         8'h11, 0, 0, 6'd0,  0,         32'd2);
    // last slot of a window shrunk by two unread bytes, then one past it
    add_row(CMD_BYTE,     0, 0, 32'd31,        8'hFF, 0, 0, 6'd0,  1,         32'd2);
    add_row(CMD_BYTE,     0, 0, 32'd32,        8'h77, 0, 0, 6'd0,  1,         32'd2);
    // eof on a dropped byte and on a far empty segment: no end recorded
    add_row(CMD_BYTE,     0, 0, 32'hFFFF_FFFF, 8'hFF, 1, 1, 6'd0,  1,         32'd2);
    add_row(CMD_EMPTY,    0, 0, 32'hFFFF_FFFF, 8'h00, 1, 0, 6'd0,  1,         32'd2);
    // oversized consume saturates the reader count at zero
    add_row(CMD_CONSUME,  0, 0, 32'd0,         8'h00, 0, 0, 6'd63, 1,         32'd2);
    add_row(CMD_BYTE,     0, 0, 32'd33,        8'h3C, 0, 1, 6'd0,  2,         32'd2);
    add_row(CMD_NOP,      0, 0, 32'hFFFF_FFFF, 8'hFF, 1, 1, 6'd63, 2,         32'd2);
    closing_from = stimulus_plan.size();

    // Closing rows, indexes relative to the head; two consumes leave the reader empty
    add_row(CMD_CONSUME,  0, 0, 32'd0,         8'h00, 0, 0, 6'd63, NOT_TYPED, 32'd0);
    add_row(CMD_CONSUME,  0, 0, 32'd0,         8'h00, 0, 0, 6'd63, NOT_TYPED, 32'd0);
    // empty eof one past the window end
    add_row(CMD_EMPTY,    1, 0, 32'd33,        8'h00, 1, 0, 6'd0,  NOT_TYPED, 32'd0);
    // eof without the segment's last byte
    add_row(CMD_BYTE,     1, 0, 32'd2,         8'hC2, 1, 0, 6'd0,  NOT_TYPED, 32'd0);
    add_row(CMD_EMPTY,    1, 1, 32'd4,         8'h00, 1, 0, 6'd0,  NOT_TYPED, 32'd0);
    // at the end index: dropped once the end is known
    add_row(CMD_BYTE,     1, 0, 32'd4,         8'hC4, 0, 0, 6'd0,  NOT_TYPED, 32'd0);
    add_row(CMD_BYTE,     1, 0, 32'd3,         8'hC3, 1, 1, 6'd0,  NOT_TYPED, 32'd0);
    // a second eof keeps the first end
    add_row(CMD_EMPTY,    1, 0, 32'd1,         8'h00, 1, 0, 6'd0,  NOT_TYPED, 32'd0);
    add_row(CMD_BYTE,     1, 0, 32'd1,         8'hC1, 0, 0, 6'd0,  NOT_TYPED, 32'd0);
    add_row(CMD_BYTE,     1, 0, 32'd0,         8'hC0, 0, 1, 6'd0,  NOT_TYPED, 32'd0);
    // after the end: data ignored, consume still frees the reader
    add_row(CMD_BYTE,     1, 0, 32'd0,         8'hEE, 0, 1, 6'd0,  NOT_TYPED, 32'd0);
    add_row(CMD_EMPTY,    1, 0, 32'd0,         8'h00, 1, 0, 6'd0,  NOT_TYPED, 32'd0);
    add_row(CMD_CONSUME,  0, 0, 32'd0,         8'h00, 0, 0, 6'd7,  NOT_TYPED, 32'd0);
    add_row(CMD_NOP,      0, 0, 32'd0,         8'h00, 0, 0, 6'd0,  NOT_TYPED, 32'd0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the table, random part between the opening and closing rows
    for (int i = 0; i < stimulus_plan.size(); i++) begin
      if (i == closing_from) random_phase();
      r = stimulus_plan[i];
      if (r.rel) r.item.stream_index = head_idx + r.item.stream_index;
      if (r.alt_nop && end_by_byte) r.item.cmd = CMD_NOP;
      send_request(r.item);
      if (r.t_pending != NOT_TYPED) begin
        // the status just queued is the last entry
        st = predicted_deliveries[predicted_deliveries.size() - 1];
        st.stream_ended = 1'b0;
        st.pending      = CNT_W'(r.t_pending);
        st.next_idx     = r.t_next;
        predicted_deliveries[predicted_deliveries.size() - 1] = st;
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then allow for a stray result
    while (predicted_deliveries.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/sbr_pkg.sv
rtl/sbr_ram.sv
rtl/sbr_admit.sv
rtl/stream_byte_reassembler_top.sv
bench/tb_stream_byte_reassembler_top.sv
